// ===== sv/multi_channel_fade_ramp_core_defines.svh =====
// assertion macros shared by the fade ramp core
`ifndef MULTI_CHANNEL_FADE_RAMP_CORE_DEFINES_SVH
`define MULTI_CHANNEL_FADE_RAMP_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MCFR_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcfr assertion failed");
`define MCFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcfr assertion failed");
`else
`define MCFR_ASSERT_IMPLY(lbl, ante, cons)
`define MCFR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/mcfr_pkg.sv =====
// types and constants of the fade ramp core
package mcfr_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_W         = 3;
    localparam int CH_DEPTH     = 2 ** CH_W;
    localparam int LVL_W        = 16;

    localparam logic [2:0] CMD_CONFIG = 3'd0;
    localparam logic [2:0] CMD_KICK   = 3'd1;
    localparam logic [2:0] CMD_KILL   = 3'd2;
    localparam logic [2:0] CMD_POLL   = 3'd3;
    localparam logic [2:0] CMD_TICK   = 3'd4;

    localparam logic [LVL_W-1:0] IDLE_LEVEL = 16'hFFFF;
    localparam logic [LVL_W-1:0] DOWN_START = 16'h7FFF;
    localparam logic [LVL_W-1:0] UP_START   = 16'h0000;
    localparam logic [LVL_W-1:0] STEP_RESET = 16'h0100;
    localparam logic [1:0]       BLEND_RESET  = 2'd1;
    localparam logic [2:0]       MASK_RESET   = 3'd3;
    localparam logic [7:0]       BUCKET_RESET = 8'd0;

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

    typedef struct packed {
        logic            wr_cfg;
        logic            wr_kick;
        logic            wr_kill;
        logic            load_poll;
        logic            load_tick;
        logic            last;
        logic [CH_W-1:0] rd_idx;
    } mcfr_cmd_t;

    typedef struct packed {
        logic in_range;
    } mcfr_stat_t;

endpackage

// ===== sv/mcfr_datapath.sv =====
// channel register bank, tick arithmetic and result register
module mcfr_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  mcfr_pkg::mcfr_cmd_t         cmd,
    output mcfr_pkg::mcfr_stat_t        stat,
    input  logic [mcfr_pkg::CH_W-1:0]   channel,
    input  logic [15:0]                 start_value,
    input  logic signed [15:0]          ramp_step,
    input  logic [1:0]                  blend_mode,
    input  logic [2:0]                  color_mask,
    input  logic [7:0]                  order_bucket,
    output logic [mcfr_pkg::CH_W-1:0]   out_channel,
    output logic                        drawn,
    output logic [7:0]                  red,
    output logic [7:0]                  green,
    output logic [7:0]                  blue,
    output logic [1:0]                  out_blend,
    output logic [7:0]                  out_bucket,
    output logic                        done_flag,
    output logic                        last
);
    import mcfr_pkg::*;

    logic [LVL_W-1:0] level_reg  [CH_DEPTH];
    logic [LVL_W-1:0] step_reg   [CH_DEPTH];
    logic [1:0]       blend_reg  [CH_DEPTH];
    logic [2:0]       mask_reg   [CH_DEPTH];
    logic [7:0]       bucket_reg [CH_DEPTH];

    logic [LVL_W-1:0] rd_level;
    logic [LVL_W-1:0] rd_step;
    logic [LVL_W-1:0] kick_level;
    logic [LVL_W-1:0] sum_level;
    logic [7:0]       bright;
    logic             active;

    logic [CH_W-1:0] ch_reg;
    logic            drawn_reg;
    logic [7:0]      red_reg;
    logic [7:0]      green_reg;
    logic [7:0]      blue_reg;
    logic [1:0]      blend_out_reg;
    logic [7:0]      bucket_out_reg;
    logic            done_reg;
    logic            last_reg;

    assign stat.in_range = ({1'b0, channel} < (CH_W + 1)'(NUM_CHANNELS));

    assign rd_level = level_reg[cmd.rd_idx];
    assign rd_step  = step_reg[cmd.rd_idx];
    assign active   = ~rd_level[LVL_W-1];
    assign bright   = rd_level[14:7];
    assign sum_level = rd_level + rd_step;

    // kick: ramp start follows step sign, zero step loads the given value
    always_comb
    begin
        if (rd_step == '0)
        begin
            kick_level = start_value;
        end
        else if (rd_step[LVL_W-1])
        begin
            kick_level = DOWN_START;
        end
        else
        begin
            kick_level = UP_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CH_DEPTH; i++)
            begin
                level_reg[i]  <= IDLE_LEVEL;
                step_reg[i]   <= STEP_RESET;
                blend_reg[i]  <= BLEND_RESET;
                mask_reg[i]   <= MASK_RESET;
                bucket_reg[i] <= BUCKET_RESET;
            end
        end
        else
        begin
            if (cmd.wr_cfg)
            begin
                step_reg[cmd.rd_idx]   <= ramp_step;
                blend_reg[cmd.rd_idx]  <= blend_mode;
                mask_reg[cmd.rd_idx]   <= color_mask;
                bucket_reg[cmd.rd_idx] <= order_bucket;
            end
            if (cmd.wr_kick)
            begin
                level_reg[cmd.rd_idx] <= kick_level;
            end
            if (cmd.wr_kill)
            begin
                level_reg[cmd.rd_idx] <= IDLE_LEVEL;
            end
            if (cmd.load_tick && active)
            begin
                level_reg[cmd.rd_idx] <= sum_level;
            end
        end
    end

    // result register, payload only
    always_ff @(posedge clk)
    begin
        if (cmd.load_poll)
        begin
            ch_reg         <= channel;
            drawn_reg      <= 1'b0;
            red_reg        <= '0;
            green_reg      <= '0;
            blue_reg       <= '0;
            blend_out_reg  <= '0;
            bucket_out_reg <= '0;
            done_reg       <= stat.in_range ? rd_level[LVL_W-1] : 1'b1;
            last_reg       <= 1'b1;
        end
        else if (cmd.load_tick)
        begin
            ch_reg         <= cmd.rd_idx;
            drawn_reg      <= active;
            red_reg        <= (active && mask_reg[cmd.rd_idx][2]) ? bright : 8'd0;
            green_reg      <= (active && mask_reg[cmd.rd_idx][1]) ? bright : 8'd0;
            blue_reg       <= (active && mask_reg[cmd.rd_idx][0]) ? bright : 8'd0;
            blend_out_reg  <= blend_reg[cmd.rd_idx];
            bucket_out_reg <= bucket_reg[cmd.rd_idx];
            done_reg       <= 1'b0;
            last_reg       <= cmd.last;
        end
    end

    assign out_channel = ch_reg;
    assign drawn       = drawn_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign out_blend   = blend_out_reg;
    assign out_bucket  = bucket_out_reg;
    assign done_flag   = done_reg;
    assign last        = last_reg;

endmodule

// ===== sv/mcfr_ctrl.sv =====
// request sequencing and tick walk state machine
`include "multi_channel_fade_ramp_core_defines.svh"
module mcfr_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  logic [2:0]                  command,
    input  logic [mcfr_pkg::CH_W-1:0]   channel,
    output logic                        res_valid,
    input  logic                        res_stall,
    output mcfr_pkg::mcfr_cmd_t         cmd,
    input  mcfr_pkg::mcfr_stat_t        stat
);
    import mcfr_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_TICK = 1'b1;

    logic            state_reg;
    logic            state_next;
    logic [CH_W-1:0] idx_reg;
    logic [CH_W-1:0] idx_next;
    logic            res_valid_reg;
    logic            res_valid_next;
    logic            slot_free;
    logic            accept;

    assign slot_free = ~res_valid_reg | ~res_stall;
    assign cmd_stall = (state_reg != ST_IDLE) | ~slot_free;
    assign accept    = cmd_valid & ~cmd_stall;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        idx_next       = idx_reg;
        res_valid_next = res_valid_reg & res_stall;
        cmd.rd_idx     = channel;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_CONFIG: cmd.wr_cfg  = stat.in_range;
                        CMD_KICK:   cmd.wr_kick = stat.in_range;
                        CMD_KILL:   cmd.wr_kill = stat.in_range;
                        CMD_POLL:
                        begin
                            cmd.load_poll  = 1'b1;
                            res_valid_next = 1'b1;
                        end
                        CMD_TICK:
                        begin
                            state_next = ST_TICK;
                            idx_next   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_TICK:
            begin
                cmd.rd_idx = idx_reg;
                cmd.last   = (idx_reg == LAST_CH);
                if (slot_free)
                begin
                    cmd.load_tick  = 1'b1;
                    res_valid_next = 1'b1;
                    idx_next       = idx_reg + 1'b1;
                    if (idx_reg == LAST_CH)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

    `MCFR_ASSERT_IMPLY(a_idx_range, state_reg == ST_TICK, {1'b0, idx_reg} < (CH_W + 1)'(NUM_CHANNELS))
    `MCFR_ASSERT_NEXT(a_tick_enters_walk, accept && command == CMD_TICK, state_reg == ST_TICK)
    `MCFR_ASSERT_NEXT(a_poll_gives_result, accept && command == CMD_POLL, res_valid_reg)
    `MCFR_ASSERT_NEXT(a_held_result_stays, res_valid_reg && res_stall, res_valid_reg)
    `MCFR_ASSERT_IMPLY(a_no_write_in_walk, state_reg == ST_TICK, !(cmd.wr_cfg || cmd.wr_kick || cmd.wr_kill))

endmodule

// ===== sv/multi_channel_fade_ramp_core.sv =====
// top level of the multi-channel screen fade ramp core
//
//   channel   direction  handshake             payload
//   request   in         cmd_valid / cmd_stall command channel start_value ramp_step
//                                              blend_mode color_mask order_bucket
//   result    out        res_valid / res_stall out_channel drawn red green blue
//                                              out_blend out_bucket done_flag last
//
// configure, kick and kill give no result
// poll gives one result, marked last, valid the cycle after the request is taken
// tick walks the channels one per cycle while the result is not stalled, through the
// shared level adder, from the cycle after the request; no request is taken during the walk
// one result register; a new request is taken in the cycle the pending result leaves
// reset puts every channel idle with default step, blend, mask and bucket
module multi_channel_fade_ramp_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  logic [2:0]                  command,
    input  logic [mcfr_pkg::CH_W-1:0]   channel,
    input  logic [15:0]                 start_value,
    input  logic signed [15:0]          ramp_step,
    input  logic [1:0]                  blend_mode,
    input  logic [2:0]                  color_mask,
    input  logic [7:0]                  order_bucket,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic [mcfr_pkg::CH_W-1:0]   out_channel,
    output logic                        drawn,
    output logic [7:0]                  red,
    output logic [7:0]                  green,
    output logic [7:0]                  blue,
    output logic [1:0]                  out_blend,
    output logic [7:0]                  out_bucket,
    output logic                        done_flag,
    output logic                        last
);
    import mcfr_pkg::*;

    // commands from the sequencer, channel range status back
    mcfr_cmd_t  dp_cmd;
    mcfr_stat_t dp_stat;

    // sequencer: request handshake, tick walk and result valid
    mcfr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .command   (command),
        .channel   (channel),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

    // channel bank and result payload register
    mcfr_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .channel      (channel),
        .start_value  (start_value),
        .ramp_step    (ramp_step),
        .blend_mode   (blend_mode),
        .color_mask   (color_mask),
        .order_bucket (order_bucket),
        .out_channel  (out_channel),
        .drawn        (drawn),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_blend    (out_blend),
        .out_bucket   (out_bucket),
        .done_flag    (done_flag),
        .last         (last)
    );

endmodule
